// ===== sv/sup_pkg.sv =====
// Package for the string-to-unsigned parser: item types, parse phases,
// character constants and the character classification helpers.
// No dependencies.
package sup_pkg;

    localparam int unsigned RADIX_W       = 6;
    localparam int unsigned COUNT_W       = 16;
    localparam int unsigned VALUE_W       = 64;
    localparam int unsigned MAX_CHARS_DEF = 65535;

    // Character codes
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_A_UP  = 8'h41;
    localparam logic [7:0] CH_Z_UP  = 8'h5A;
    localparam logic [7:0] CH_A_LO  = 8'h61;
    localparam logic [7:0] CH_Z_LO  = 8'h7A;
    localparam logic [7:0] CH_X_UP  = 8'h58;
    localparam logic [7:0] CH_X_LO  = 8'h78;

    localparam logic [RADIX_W-1:0] BASE_AUTO = 6'd0;
    localparam logic [RADIX_W-1:0] BASE_OCT  = 6'd8;
    localparam logic [RADIX_W-1:0] BASE_DEC  = 6'd10;
    localparam logic [RADIX_W-1:0] BASE_HEX  = 6'd16;

    typedef enum logic [2:0] {
        PH_SPACE,
        PH_PREFIX,
        PH_ZERO,
        PH_DIGITS,
        PH_STOP
    } phase_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       has_char;
        logic       last;
    } char_item_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [COUNT_W-1:0] consumed;
        logic               value_written;
    } res_item_t;

    typedef struct packed {
        logic               ok;
        logic [RADIX_W-1:0] val;
    } digit_t;

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    // Digit value 0..35 for 0-9, A-Z, a-z
    function automatic digit_t digit_of(input logic [7:0] c);
        digit_t     d;
        logic [7:0] off;
        d   = '0;
        off = '0;
        if ((c >= CH_ZERO) && (c <= CH_NINE))
        begin
            off  = c - CH_ZERO;
            d.ok = 1'b1;
        end
        else if ((c >= CH_A_UP) && (c <= CH_Z_UP))
        begin
            off  = c - CH_A_UP + 8'd10;
            d.ok = 1'b1;
        end
        else if ((c >= CH_A_LO) && (c <= CH_Z_LO))
        begin
            off  = c - CH_A_LO + 8'd10;
            d.ok = 1'b1;
        end
        d.val = off[RADIX_W-1:0];
        return d;
    endfunction

endpackage

// ===== sv/sup_stream_if.sv =====
// Valid/ready channel with a typed payload, used for the character,
// result and radix-write channels of the parser. No dependencies.
interface sup_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== sv/string_to_unsigned_parser_unit.sv =====
// Pipeline: a character transaction is held in the input register and is applied
// to the parse state as it leaves that register; an item with last set loads the result
// register at the same edge, which raises result.valid.
// Throughput: one character per cycle (single 64x6 multiply-add); an item with last set
// waits only while the previous result is still held by a stalled sink.
// Reset: rst_n clears control, parse state and radix; depends on sup_pkg, sup_stream_if.
module string_to_unsigned_parser_unit #(
    parameter int unsigned MAX_CHARS = sup_pkg::MAX_CHARS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    sup_stream_if.sink   cfg,
    sup_stream_if.sink   chars,
    sup_stream_if.source result
);
    import sup_pkg::*;

    localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(MAX_CHARS);

    // ------------------------------------------------------------------
    // Radix register. The user must write it only while the parser is idle (not
    // enforced here), so the whitespace phase may read it directly in place of sampling.
    // ------------------------------------------------------------------
    logic [RADIX_W-1:0] radix_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            radix_reg <= BASE_AUTO;
        else if (cfg.valid)
            radix_reg <= cfg.payload;
    end

    // ------------------------------------------------------------------
    // Input register stage
    // ------------------------------------------------------------------
    logic       s1_valid_reg;
    logic       s1_valid_next;
    char_item_t s1_item_reg;
    logic       s1_adv;       // stage 1 hands its character on this cycle
    logic       upd;          // parse state takes the character
    logic       res_load;

    logic      res_valid_reg;
    logic      res_valid_next;
    res_item_t res_item_reg;
    res_item_t res_item_next;

    // ------------------------------------------------------------------
    // Parse state. The accumulator holds the value with the sign already
    // applied: the sign is always seen before any digit, when the
    // accumulator is still zero, so acc*b + (-d) tracks -(value) exactly.
    // ------------------------------------------------------------------
    phase_t             phase_reg,  phase_next;
    logic [VALUE_W-1:0] acc_reg,    acc_next;
    logic [COUNT_W-1:0] count_reg,  count_next;
    logic               neg_reg,    neg_next;
    logic [RADIX_W-1:0] base_reg,   base_next;

    // State after this character, before the end-of-string clear
    phase_t             phase_post;
    logic [VALUE_W-1:0] acc_post;
    logic [COUNT_W-1:0] count_post;
    logic               neg_post;
    logic [RADIX_W-1:0] base_post;

    logic [COUNT_W-1:0] count_inc;
    logic [RADIX_W-1:0] pre_base;     // base seen by the prefix check
    logic [RADIX_W-1:0] digit_base;   // base used for a digit attempt
    logic               try_digit;
    digit_t             dig;
    logic [7:0]         c;

    assign c         = s1_item_reg.ch;
    assign dig       = digit_of(c);
    assign count_inc = (count_reg < COUNT_MAX) ? count_reg + 1'b1 : count_reg;
    assign pre_base  = (phase_reg == PH_SPACE) ? radix_reg : base_reg;

    // Next-state logic of the parser
    always_comb
    begin
        phase_post = phase_reg;
        acc_post   = acc_reg;
        count_post = count_reg;
        neg_post   = neg_reg;
        base_post  = base_reg;
        try_digit  = 1'b0;
        digit_base = base_reg;

        if (upd && s1_item_reg.has_char)
        begin
            unique case (phase_reg)
                PH_SPACE, PH_PREFIX:
                begin
                    base_post = pre_base;
                    if ((phase_reg == PH_SPACE) && is_space(c))
                    begin
                        count_post = count_inc;
                    end
                    else if ((phase_reg == PH_SPACE) && ((c == CH_PLUS) || (c == CH_MINUS)))
                    begin
                        neg_post   = (c == CH_MINUS);
                        count_post = count_inc;
                        phase_post = PH_PREFIX;
                    end
                    else if (((pre_base == BASE_AUTO) || (pre_base == BASE_HEX))
                             && (c == CH_ZERO))
                    begin
                        // leading zero: may open a hex prefix or an octal number
                        count_post = count_inc;
                        phase_post = PH_ZERO;
                    end
                    else
                    begin
                        try_digit  = 1'b1;
                        digit_base = (pre_base == BASE_AUTO) ? BASE_DEC : pre_base;
                    end
                end
                PH_ZERO:
                begin
                    if ((c == CH_X_LO) || (c == CH_X_UP))
                    begin
                        base_post  = BASE_HEX;
                        count_post = count_inc;
                        phase_post = PH_DIGITS;
                    end
                    else
                    begin
                        try_digit  = 1'b1;
                        digit_base = (base_reg == BASE_AUTO) ? BASE_OCT : base_reg;
                    end
                end
                PH_DIGITS:
                begin
                    try_digit = 1'b1;
                end
                PH_STOP:
                begin
                    // characters after the first invalid digit are ignored
                end
                default:
                begin
                    phase_post = PH_STOP;
                end
            endcase

            if (try_digit)
            begin
                base_post = digit_base;
                if (dig.ok && (dig.val < digit_base))
                begin
                    acc_post   = acc_reg * VALUE_W'(digit_base)
                               + (neg_reg ? -VALUE_W'(dig.val) : VALUE_W'(dig.val));
                    count_post = count_inc;
                    phase_post = PH_DIGITS;
                end
                else
                begin
                    phase_post = PH_STOP;
                end
            end
        end

        // End of string: report, then back to the reset state
        if (upd && s1_item_reg.last)
        begin
            phase_next = PH_SPACE;
            acc_next   = '0;
            count_next = '0;
            neg_next   = 1'b0;
            base_next  = BASE_AUTO;
        end
        else
        begin
            phase_next = phase_post;
            acc_next   = acc_post;
            count_next = count_post;
            neg_next   = neg_post;
            base_next  = base_post;
        end
    end

    // Handshake and result logic. The result register is the skid point:
    // only an item carrying last waits for it, others flow straight through.
    always_comb
    begin
        s1_adv       = s1_valid_reg
                     && (!s1_item_reg.last || !res_valid_reg || result.ready);
        upd          = s1_adv;
        chars.ready  = !s1_valid_reg || s1_adv;
        s1_valid_next = chars.valid || (s1_valid_reg && !s1_adv);

        res_load = upd && s1_item_reg.last;
        res_item_next.value         = acc_post;
        res_item_next.consumed      = count_post;
        res_item_next.value_written = (count_post != '0);

        if (res_load)
            res_valid_next = 1'b1;
        else if (result.ready)
            res_valid_next = 1'b0;
        else
            res_valid_next = res_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            phase_reg     <= PH_SPACE;
            acc_reg       <= '0;
            count_reg     <= '0;
            neg_reg       <= 1'b0;
            base_reg      <= BASE_AUTO;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
            phase_reg     <= phase_next;
            acc_reg       <= acc_next;
            count_reg     <= count_next;
            neg_reg       <= neg_next;
            base_reg      <= base_next;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (chars.ready && chars.valid)
            s1_item_reg <= chars.payload;
        if (res_load)
            res_item_reg <= res_item_next;
    end

    assign result.valid   = res_valid_reg;
    assign result.payload = res_item_reg;

`ifndef SYNTHESIS
    // A reported value is flagged exactly when characters were consumed
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> (res_item_reg.value_written == (res_item_reg.consumed != '0)))
    else $error("value_written disagrees with consumed");

    // Consumed count saturates at the limit
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_MAX)
    else $error("character count above limit");

    // No digit has been taken before the digits phase
    assert property (@(posedge clk) disable iff (!rst_n)
        ((phase_reg == PH_SPACE) || (phase_reg == PH_PREFIX) || (phase_reg == PH_ZERO))
        |-> (acc_reg == '0))
    else $error("accumulator non-zero before any digit");

    // Once digits are taken or parsing stops, a concrete base is held
    assert property (@(posedge clk) disable iff (!rst_n)
        ((phase_reg == PH_DIGITS) || (phase_reg == PH_STOP)) |-> (base_reg != BASE_AUTO))
    else $error("no base resolved after prefix");

    // A transaction with neither character nor end leaves the state alone
    assert property (@(posedge clk) disable iff (!rst_n)
        (upd && !s1_item_reg.has_char && !s1_item_reg.last)
        |=> ($stable(acc_reg) && $stable(count_reg) && (phase_reg == $past(phase_reg))))
    else $error("empty transaction changed parse state");
`endif

endmodule
